FILE: sv/swm_pkg.sv
// Shared constants, types and helpers for the sliding window maximum unit.
package swm_pkg;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 16;
   localparam int IDX_W        = $clog2(MAX_WINDOW);
   localparam int WIN_W        = 7;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);
   localparam logic [WIN_W-1:0] WINDOW_MIN   = WIN_W'(1);
   localparam logic [WIN_W-1:0] WINDOW_MAX   = WIN_W'(MAX_WINDOW);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [WIN_W-1:0]               window_type;
   typedef logic [IDX_W-1:0]               tap_type;

   // broadcast to the whole chain
   typedef struct packed {
      logic       load;
      logic       empty;
      sample_type sample;
   } chain_ctrl_type;

   // broadcast to every cell
   typedef struct packed {
      logic       load;
      logic       empty;
      sample_type sample;
      sample_type tail;
   } cell_ctrl_type;

   // clamp the programmed window size into 1..MAX_WINDOW
   function automatic window_type clamp_window(input window_type raw);
      window_type res;
      res = raw;
      if (raw < WINDOW_MIN) begin
         res = WINDOW_MIN;
      end else if (raw > WINDOW_MAX) begin
         res = WINDOW_MAX;
      end
      return res;
   endfunction

endpackage

FILE: sv/swm_channels.sv
// Handshake channel interfaces: sample input, result output and window size write.
interface swm_req_if import swm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       end_of_stream;

   modport source (output valid, output sample, output end_of_stream, input ready);
   modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

interface swm_rsp_if import swm_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type window_max;
   logic       final_result;

   modport source (output valid, output window_max, output final_result, input ready);
   modport sink   (input valid, input window_max, input final_result, output ready);
endinterface

interface swm_csr_if import swm_pkg::*; ();
   logic       valid;
   logic       ready;
   window_type window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

FILE: sv/swm_cell.sv
// One cell of the chain: holds the maximum of the retained samples up to its age.
module swm_cell import swm_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          in_window,
   input  sample_type    prev_value,
   output sample_type    value
);

   sample_type value_ff;
   sample_type value_in;
   sample_type cand;

   // take the neighbor's running maximum against the new sample
   assign cand = (ctrl.empty || (ctrl.sample >= prev_value)) ? ctrl.sample : prev_value;
   // past the window edge every cell mirrors the front of the window
   assign value_in = in_window ? cand : ctrl.tail;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

FILE: sv/swm_chain.sv
// Row of cells plus the window edge tap that yields the next front value.
module swm_chain import swm_pkg::*; (
   input  logic           clock,
   input  chain_ctrl_type ctrl,
   input  window_type     window_eff,
   output sample_type     front
);

   sample_type    cell_value [MAX_WINDOW];
   sample_type    tap_value;
   tap_type       tap;
   window_type    tap_wide;
   logic          single;
   cell_ctrl_type cell_ctrl;

   // read the cell one short of the window edge
   assign tap_wide  = window_eff - WIN_W'(2);
   assign tap       = tap_wide[IDX_W-1:0];
   assign tap_value = cell_value[tap];
   assign single    = (window_eff == WINDOW_MIN);

   assign front = (single || ctrl.empty || (ctrl.sample >= tap_value)) ? ctrl.sample
                                                                        : tap_value;

   assign cell_ctrl.load   = ctrl.load;
   assign cell_ctrl.empty  = ctrl.empty;
   assign cell_ctrl.sample = ctrl.sample;
   assign cell_ctrl.tail   = front;

   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      localparam window_type CellAge = WIN_W'(k);
      logic       in_window;
      sample_type prev_value;

      assign in_window = (CellAge < window_eff);
      if (k == 0) begin : g_head
         assign prev_value = ctrl.sample;
      end else begin : g_link
         assign prev_value = cell_value[k-1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .in_window  (in_window),
         .prev_value (prev_value),
         .value      (cell_value[k])
      );
   end

endmodule

FILE: sv/sliding_window_max_unit.sv
// Top level of the sliding window maximum unit.
// Usage:
//   req_ch carries one signed sample per item plus end_of_stream, which marks
//   the last sample of a stream. rsp_ch carries window_max and final_result.
//   csr_ch writes the window size (always ready); write it only while idle.
//   A size of 0 acts as 1, a size above 64 acts as 64. Reset value is 3.
// Timing:
//   One item per cycle while rsp_ch does not stall. A result appears on rsp_ch in the cycle after the item
//   that caused it is accepted; it is held in a single output register.
//   Once window-size samples of the stream are in, every item yields the
//   maximum of the last window-size samples. An end_of_stream item always
//   yields a result (the maximum of the whole stream if it was short) with
//   final_result set, and starts a fresh stream.
// Structure:
//   A row of 64 cells; cell k keeps the maximum of the retained samples aged
//   up to k. On each accepted item every cell folds the new sample into its neighbor's
//   value, so the sample rate is set by one compare per cell and the tap mux.
// Reset: synchronous, active high; clears the stream and the output valid flag and restores the window size.
// Stall: while a result waits and rsp_ch.ready is low, req_ch.ready is low.
module sliding_window_max_unit import swm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   swm_req_if.sink     req_ch,
   swm_rsp_if.source   rsp_ch,
   swm_csr_if.sink     csr_ch
);

   window_type     window_ff;
   window_type     window_in;
   window_type     window_eff;
   window_type     seen_ff;
   window_type     seen_in;
   window_type     seen_next;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   sample_type     rsp_max_ff;
   logic           rsp_final_ff;
   logic           accept;
   logic           emit;
   sample_type     front;
   chain_ctrl_type chain_ctrl;

   // window size register
   assign csr_ch.ready = 1'b1;
   assign window_in    = (csr_ch.valid) ? csr_ch.window_size : window_ff;
   assign window_eff   = clamp_window(window_ff);

   // accept whenever the output register is free or being drained
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // count stream samples, saturate at the window size
   assign seen_next = (seen_ff < window_eff) ? (seen_ff + WIN_W'(1)) : window_eff;
   assign emit      = (seen_next >= window_eff) || req_ch.end_of_stream;

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         seen_in = (req_ch.end_of_stream) ? '0 : seen_next;
      end
   end

   // the stream is empty until its first sample; cell contents are then stale
   assign chain_ctrl.load   = accept;
   assign chain_ctrl.empty  = (seen_ff == '0);
   assign chain_ctrl.sample = req_ch.sample;

   swm_chain u_chain (
      .clock      (clock),
      .ctrl       (chain_ctrl),
      .window_eff (window_eff),
      .front      (front)
   );

   // output register: load on an emitting item, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_max_ff   <= front;
         rsp_final_ff <= req_ch.end_of_stream;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.window_max   = rsp_max_ff;
   assign rsp_ch.final_result = rsp_final_ff;

endmodule
